>>> hw/rtl/flcf_pkg.sv
// Package for the floppy LBA command formatter.
// Transaction structs, register indexes, reset values and command byte constants.
// No dependencies.
package flcf_pkg;

   typedef struct packed {
      logic [15:0] block_number;
      logic        is_read;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] command_byte;
      logic [3:0] byte_position;
      logic       last_byte;
      logic       range_error;
   } rsp_payload_type;

   localparam logic [2:0] REG_SECTORS_PER_TRACK = 3'd0;
   localparam logic [2:0] REG_HEAD_COUNT        = 3'd1;
   localparam logic [2:0] REG_GAP_LENGTH        = 3'd2;
   localparam logic [2:0] REG_READ_OPCODE       = 3'd3;
   localparam logic [2:0] REG_WRITE_OPCODE      = 3'd4;

   localparam logic [5:0] SPT_RESET    = 6'd18;
   localparam logic [1:0] HEADS_RESET  = 2'd2;
   localparam logic [7:0] GAP_RESET    = 8'h1B;
   localparam logic [7:0] RD_OP_RESET  = 8'd230;
   localparam logic [7:0] WR_OP_RESET  = 8'd197;

   localparam logic [7:0] SIZE_CODE    = 8'h02;
   localparam logic [7:0] DTL_BYTE     = 8'hFF;

   localparam logic [3:0] POS_OPCODE   = 4'd0;
   localparam logic [3:0] POS_HEAD_SEL = 4'd1;
   localparam logic [3:0] POS_CYL      = 4'd2;
   localparam logic [3:0] POS_HEAD     = 4'd3;
   localparam logic [3:0] POS_SECTOR   = 4'd4;
   localparam logic [3:0] POS_SIZE     = 4'd5;
   localparam logic [3:0] POS_EOT      = 4'd6;
   localparam logic [3:0] POS_GAP      = 4'd7;
   localparam logic [3:0] POS_DTL      = 4'd8;

   // floor(x / 3) == (x * RECIP_3) >> 17 for every 16-bit x
   localparam logic [16:0] RECIP_3     = 17'd43691;

endpackage

>>> hw/rtl/floppy_lba_command_formatter_unit.sv
// Floppy LBA command formatter: block number to CHS, then nine-byte command stream.
// Uses flcf_pkg for transaction structs and constants.
//
// Usage:
//  - Request: drive req_data and raise start; the transaction is taken at a rising
//    edge with start high and busy low. Requests may be issued every cycle while
//    busy is low.
//  - Response: nine transactions per request (opcode, head<<2, cylinder, head,
//    sector, size code, sectors per track, gap, 0xFF), each valid for one cycle
//    with rsp_strobe high; the ninth has last_byte set. A cylinder above 255, or a
//    zero sector or head count, gives a single transaction with range_error set.
//  - CSR: csr_valid/csr_ready write channel; csr_ready is always high. Write only
//    while no request is in flight. Indexes beyond 4 are ignored.
//  - Pipeline: the accepted request is registered, then passes a 16-bit restoring
//    divide over four stages of four bits, a divide by the head count, a head/range
//    stage, then the byte serializer that drives the response ports.
//  - Throughput: the serializer sends one byte per cycle and takes a new request
//    only after the last byte of the one before; an error request gives one transaction.
//    Up to seven requests queue; busy rises when the serializer cannot drain the pipeline.
//  - Reset: synchronous; empties the pipeline and loads the default geometry
//    (18 sectors, 2 heads, gap 0x1B, read 0xE6, write 0xC5).
//  - The receiver cannot stall; no response is ever held back from the ports.
module floppy_lba_command_formatter_unit
   import flcf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [7:0]      csr_data
);

   typedef struct packed {
      logic        valid;
      logic        is_read;
      logic [15:0] num;
      logic [15:0] quot;
      logic [5:0]  rem;
   } div_stage_type;

   typedef struct packed {
      logic        valid;
      logic        is_read;
      logic [15:0] quot;
      logic [5:0]  rem;
      logic [15:0] cyl;
   } mid_stage_type;

   typedef struct packed {
      logic       valid;
      logic       is_read;
      logic       err;
      logic [7:0] cyl;
      logic [1:0] head;
      logic [5:0] sector;
   } fin_stage_type;

   logic [5:0] spt_ff, spt_in;
   logic [1:0] heads_ff, heads_in;
   logic [7:0] gap_ff, gap_in;
   logic [7:0] rd_op_ff, rd_op_in;
   logic [7:0] wr_op_ff, wr_op_in;

   div_stage_type div_ff [0:4];
   div_stage_type div_in [0:4];
   mid_stage_type mid_ff, mid_in;
   fin_stage_type fin_ff, fin_in;
   fin_stage_type ser_ff, ser_in;
   logic [3:0]    pos_ff, pos_in;

   logic        advance;
   logic        accept;
   logic        ser_free;
   logic [32:0] prod3;
   logic [17:0] prod_hc;

   function automatic div_stage_type div_step(div_stage_type s, logic [5:0] d);
      logic [6:0]    t;
      div_stage_type r;
      r = s;
      t = {s.rem, s.num[15]};
      r.num = {s.num[14:0], 1'b0};
      if (t >= {1'b0, d}) begin
         r.rem  = 6'(t - {1'b0, d});
         r.quot = {s.quot[14:0], 1'b1};
      end else begin
         r.rem  = t[5:0];
         r.quot = {s.quot[14:0], 1'b0};
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign advance   = !(fin_ff.valid && !ser_free);
   assign busy      = !advance;
   assign accept    = start && !busy;

   // configuration registers
   always_comb begin
      spt_in   = spt_ff;
      heads_in = heads_ff;
      gap_in   = gap_ff;
      rd_op_in = rd_op_ff;
      wr_op_in = wr_op_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SECTORS_PER_TRACK: spt_in   = csr_data[5:0];
            REG_HEAD_COUNT:        heads_in = csr_data[1:0];
            REG_GAP_LENGTH:        gap_in   = csr_data;
            REG_READ_OPCODE:       rd_op_in = csr_data;
            REG_WRITE_OPCODE:      wr_op_in = csr_data;
            default: ;
         endcase
      end
   end

   // divide pipeline: block / sectors_per_track, four quotient bits per stage
   always_comb begin
      div_in[0].valid   = accept;
      div_in[0].is_read = req_data.is_read;
      div_in[0].num     = req_data.block_number;
      div_in[0].quot    = '0;
      div_in[0].rem     = '0;
      for (int s = 1; s < 5; s++) begin
         div_in[s] = div_ff[s-1];
         for (int k = 0; k < 4; k++) begin
            div_in[s] = div_step(div_in[s], spt_ff);
         end
      end
   end

   // divide quotient by head count
   always_comb begin
      prod3          = 33'(div_ff[4].quot) * 33'(RECIP_3);
      mid_in.valid   = div_ff[4].valid;
      mid_in.is_read = div_ff[4].is_read;
      mid_in.quot    = div_ff[4].quot;
      mid_in.rem     = div_ff[4].rem;
      case (heads_ff)
         2'd2:    mid_in.cyl = {1'b0, div_ff[4].quot[15:1]};
         2'd3:    mid_in.cyl = prod3[32:17];
         default: mid_in.cyl = div_ff[4].quot;
      endcase
   end

   // head, sector and range check
   always_comb begin
      prod_hc        = {2'b00, mid_ff.cyl} * {16'd0, heads_ff};
      fin_in.valid   = mid_ff.valid;
      fin_in.is_read = mid_ff.is_read;
      fin_in.err     = (spt_ff == '0) || (heads_ff == '0) || (mid_ff.cyl[15:8] != '0);
      fin_in.cyl     = mid_ff.cyl[7:0];
      fin_in.head    = 2'(mid_ff.quot[1:0] - prod_hc[1:0]);
      fin_in.sector  = 6'(mid_ff.rem + 6'd1);
   end

   // byte serializer
   always_comb begin
      rsp_strobe                = ser_ff.valid;
      rsp_payload.range_error   = ser_ff.err;
      rsp_payload.byte_position = ser_ff.err ? POS_OPCODE : pos_ff;
      rsp_payload.last_byte     = ser_ff.err || (pos_ff == POS_DTL);
      if (ser_ff.err) begin
         rsp_payload.command_byte = '0;
      end else begin
         case (pos_ff)
            POS_OPCODE:   rsp_payload.command_byte = ser_ff.is_read ? rd_op_ff : wr_op_ff;
            POS_HEAD_SEL: rsp_payload.command_byte = {4'd0, ser_ff.head, 2'b00};
            POS_CYL:      rsp_payload.command_byte = ser_ff.cyl;
            POS_HEAD:     rsp_payload.command_byte = {6'd0, ser_ff.head};
            POS_SECTOR:   rsp_payload.command_byte = {2'b00, ser_ff.sector};
            POS_SIZE:     rsp_payload.command_byte = SIZE_CODE;
            POS_EOT:      rsp_payload.command_byte = {2'b00, spt_ff};
            POS_GAP:      rsp_payload.command_byte = gap_ff;
            POS_DTL:      rsp_payload.command_byte = DTL_BYTE;
            default:      rsp_payload.command_byte = '0;
         endcase
      end
      ser_free = !ser_ff.valid || rsp_payload.last_byte;
      ser_in   = ser_ff;
      pos_in   = pos_ff;
      if (ser_free) begin
         ser_in       = fin_ff;
         ser_in.valid = fin_ff.valid;
         pos_in       = POS_OPCODE;
      end else begin
         pos_in = 4'(pos_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff       <= SPT_RESET;
         heads_ff     <= HEADS_RESET;
         gap_ff       <= GAP_RESET;
         rd_op_ff     <= RD_OP_RESET;
         wr_op_ff     <= WR_OP_RESET;
         for (int s = 0; s < 5; s++) begin
            div_ff[s].valid <= 1'b0;
         end
         mid_ff.valid <= 1'b0;
         fin_ff.valid <= 1'b0;
         ser_ff.valid <= 1'b0;
      end else begin
         spt_ff   <= spt_in;
         heads_ff <= heads_in;
         gap_ff   <= gap_in;
         rd_op_ff <= rd_op_in;
         wr_op_ff <= wr_op_in;
         if (advance) begin
            for (int s = 0; s < 5; s++) begin
               div_ff[s] <= div_in[s];
            end
            mid_ff <= mid_in;
            fin_ff <= fin_in;
         end
         ser_ff <= ser_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.range_error |->
         rsp_payload.last_byte && (rsp_payload.byte_position == POS_OPCODE))
      else $error("error transaction not a single last byte");

   a_cmd_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last_byte |=>
         rsp_strobe && !rsp_payload.range_error &&
         (rsp_payload.byte_position == 4'($past(rsp_payload.byte_position) + 4'd1)))
      else $error("command stream broken");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      busy |-> fin_ff.valid && ser_ff.valid && !rsp_payload.last_byte)
      else $error("busy without a blocked serializer");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> div_ff[0].valid)
      else $error("accepted request not in pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(fin_ff))
      else $error("final stage changed during stall");

endmodule
